[design/preemptive_priority_scheduler_unit_macros.svh]
// Assertion macros used by the checker file of the scheduler.
// No dependencies.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define PPSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ppsu_pkg.sv]
// Package of the preemptive priority scheduler: sizes, table entry layout,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppsu_pkg;

	localparam int MAX_PROCS  = 16;
	localparam int SLOT_W     = $clog2(MAX_PROCS);
	localparam int COUNT_W    = $clog2(MAX_PROCS + 1);
	localparam int TIME_W     = 16;
	localparam int PRIO_W     = 8;
	localparam int RUN_SLOT_W = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
		logic              done;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic accept;
		logic load_write;
		logic scan_issue;
		logic update;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic req_tick;
		logic has_work;
		logic scan_end;
	} status_t;

	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] t);
		sat_inc = (t == TIME_MAX) ? TIME_MAX : t + 1'b1;
	endfunction

endpackage

`default_nettype wire

[design/ppsu_req_if.sv]
// Request channel of the scheduler: valid/ready plus one request word.
// Depends on ppsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppsu_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [ppsu_pkg::TIME_W-1:0]     arrival_time;
	logic [ppsu_pkg::TIME_W-1:0]     burst_length;
	logic [ppsu_pkg::PRIO_W-1:0]     priority_level;

	modport source (output valid, req_type, arrival_time, burst_length, priority_level,
		input ready);
	modport sink (input valid, req_type, arrival_time, burst_length, priority_level,
		output ready);
endinterface

`default_nettype wire

[design/ppsu_rsp_if.sv]
// Result channel of the scheduler: valid/ready plus one result word.
// Depends on ppsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppsu_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            run_valid;
	logic [ppsu_pkg::RUN_SLOT_W-1:0] run_slot;
	logic                            switched;
	logic                            finished;
	logic [ppsu_pkg::TIME_W-1:0]     turnaround;
	logic [ppsu_pkg::TIME_W-1:0]     waiting;
	logic [ppsu_pkg::TIME_W-1:0]     time_after;
	logic                            all_done;
	logic                            rejected;

	modport source (output valid, run_valid, run_slot, switched, finished, turnaround,
		waiting, time_after, all_done, rejected, input ready);
	modport sink (input valid, run_valid, run_slot, switched, finished, turnaround,
		waiting, time_after, all_done, rejected, output ready);
endinterface

`default_nettype wire

[design/ppsu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/ppsu_dp.sv]
// Scheduler datapath: process table RAM, winner search registers, counters,
// clock and result registers. Driven by ppsu_ctrl; depends on ppsu_pkg, ppsu_ram.
`timescale 1ns / 1ps
`default_nettype none

module ppsu_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ppsu_pkg::cmd_t                    cmd,
	output ppsu_pkg::status_t                      status,
	input  wire logic                              req_type,
	input  wire logic [ppsu_pkg::TIME_W-1:0]       arrival_time,
	input  wire logic [ppsu_pkg::TIME_W-1:0]       burst_length,
	input  wire logic [ppsu_pkg::PRIO_W-1:0]       priority_level,
	output logic                                   run_valid,
	output logic [ppsu_pkg::RUN_SLOT_W-1:0]        run_slot,
	output logic                                   switched,
	output logic                                   finished,
	output logic [ppsu_pkg::TIME_W-1:0]            turnaround,
	output logic [ppsu_pkg::TIME_W-1:0]            waiting,
	output logic [ppsu_pkg::TIME_W-1:0]            time_after,
	output logic                                   all_done,
	output logic                                   rejected
);

	// captured request
	logic                            req_tick_q;
	logic [ppsu_pkg::TIME_W-1:0]     in_arr_q;
	logic [ppsu_pkg::TIME_W-1:0]     in_burst_q;
	logic [ppsu_pkg::PRIO_W-1:0]     in_prio_q;

	// scheduler state
	logic [ppsu_pkg::COUNT_W-1:0]    proc_cnt_q;
	logic [ppsu_pkg::COUNT_W-1:0]    fin_cnt_q;
	logic [ppsu_pkg::COUNT_W-1:0]    issue_q;
	logic [ppsu_pkg::TIME_W-1:0]     clock_q;
	logic                            last_valid_q;
	logic [ppsu_pkg::SLOT_W-1:0]     last_slot_q;

	// scan
	logic                            pend_s1;
	logic [ppsu_pkg::SLOT_W-1:0]     pend_idx_s1;
	logic                            found_q;
	logic [ppsu_pkg::SLOT_W-1:0]     best_idx_q;
	ppsu_pkg::entry_t                best_q;

	// staged result
	logic                            st_run_valid_q;
	logic [ppsu_pkg::RUN_SLOT_W-1:0] st_slot_q;
	logic                            st_switched_q;
	logic                            st_finished_q;
	logic [ppsu_pkg::TIME_W-1:0]     st_turn_q;
	logic [ppsu_pkg::TIME_W-1:0]     st_burst_q;
	logic                            st_rejected_q;

	// RAM
	logic                            ram_we;
	logic [ppsu_pkg::SLOT_W-1:0]     ram_waddr;
	ppsu_pkg::entry_t                ram_wentry;
	logic [ppsu_pkg::ENTRY_W-1:0]    ram_rword;
	ppsu_pkg::entry_t                rd_entry;

	logic                            full;
	logic                            do_load;
	logic                            can_issue;
	logic                            eligible;
	logic                            better;
	logic                            fin_now;
	logic [ppsu_pkg::TIME_W-1:0]     clk_inc;
	logic [ppsu_pkg::TIME_W-1:0]     turn_calc;
	ppsu_pkg::entry_t                upd_entry;
	ppsu_pkg::entry_t                new_entry;

	ppsu_ram #(
		.WIDTH(ppsu_pkg::ENTRY_W),
		.DEPTH(ppsu_pkg::MAX_PROCS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.raddr(issue_q[ppsu_pkg::SLOT_W-1:0]),
		.rdata(ram_rword)
	);

	assign rd_entry  = ppsu_pkg::entry_t'(ram_rword);
	assign full      = (proc_cnt_q == ppsu_pkg::COUNT_W'(ppsu_pkg::MAX_PROCS));
	assign do_load   = cmd.load_write && (req_tick_q == ppsu_pkg::REQ_LOAD) && !full;
	assign can_issue = cmd.scan_issue && (issue_q < proc_cnt_q);

	assign eligible = pend_s1 && !rd_entry.done && (rd_entry.arrival <= clock_q);
	assign better   = !found_q || (rd_entry.prio < best_q.prio) ||
		((rd_entry.prio == best_q.prio) && (rd_entry.arrival < best_q.arrival));

	assign fin_now   = (best_q.remaining <= ppsu_pkg::TIME_W'(1));
	assign clk_inc   = ppsu_pkg::sat_inc(clock_q);
	assign turn_calc = clk_inc - best_q.arrival;

	always_comb begin
		new_entry           = '0;
		new_entry.arrival   = in_arr_q;
		new_entry.burst     = in_burst_q;
		new_entry.remaining = in_burst_q;
		new_entry.prio      = in_prio_q;
		new_entry.done      = 1'b0;

		upd_entry = best_q;
		if (fin_now) begin
			upd_entry.remaining = '0;
			upd_entry.done      = 1'b1;
		end else begin
			upd_entry.remaining = best_q.remaining - 1'b1;
		end

		ram_we     = 1'b0;
		ram_waddr  = best_idx_q;
		ram_wentry = upd_entry;
		if (do_load) begin
			ram_we     = 1'b1;
			ram_waddr  = proc_cnt_q[ppsu_pkg::SLOT_W-1:0];
			ram_wentry = new_entry;
		end else if (cmd.update && found_q) begin
			ram_we = 1'b1;
		end
	end

	assign status.req_tick = (req_tick_q == ppsu_pkg::REQ_TICK);
	assign status.has_work = (fin_cnt_q < proc_cnt_q);
	assign status.scan_end = (issue_q == proc_cnt_q) && !pend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_cnt_q   <= '0;
			fin_cnt_q    <= '0;
			issue_q      <= '0;
			clock_q      <= '0;
			last_valid_q <= 1'b0;
			last_slot_q  <= '0;
			pend_s1      <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			pend_s1 <= can_issue;
			if (cmd.accept) begin
				found_q <= 1'b0;
				issue_q <= '0;
			end else if (can_issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (eligible && better) begin
				found_q <= 1'b1;
			end
			if (do_load) begin
				proc_cnt_q <= proc_cnt_q + 1'b1;
			end
			if (cmd.update) begin
				clock_q <= clk_inc;
				if (found_q) begin
					last_valid_q <= 1'b1;
					last_slot_q  <= best_idx_q;
					if (fin_now) begin
						fin_cnt_q <= fin_cnt_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_s1 <= issue_q[ppsu_pkg::SLOT_W-1:0];
		if (cmd.accept) begin
			req_tick_q     <= req_type;
			in_arr_q       <= arrival_time;
			in_burst_q     <= burst_length;
			in_prio_q      <= priority_level;
			st_run_valid_q <= 1'b0;
			st_slot_q      <= '0;
			st_switched_q  <= 1'b0;
			st_finished_q  <= 1'b0;
			st_turn_q      <= '0;
			st_burst_q     <= '0;
			st_rejected_q  <= 1'b0;
		end
		if (eligible && better) begin
			best_idx_q <= pend_idx_s1;
			best_q     <= rd_entry;
		end
		if (cmd.load_write && (req_tick_q == ppsu_pkg::REQ_LOAD) && full) begin
			st_rejected_q <= 1'b1;
		end
		if (cmd.update && found_q) begin
			st_run_valid_q <= 1'b1;
			st_slot_q      <= ppsu_pkg::RUN_SLOT_W'(best_idx_q);
			st_switched_q  <= !last_valid_q || (last_slot_q != best_idx_q);
			if (fin_now) begin
				st_finished_q <= 1'b1;
				st_turn_q     <= turn_calc;
				st_burst_q    <= best_q.burst;
			end
		end
		if (cmd.emit) begin
			run_valid  <= st_run_valid_q;
			run_slot   <= st_slot_q;
			switched   <= st_switched_q;
			finished   <= st_finished_q;
			turnaround <= st_turn_q;
			waiting    <= (st_turn_q > st_burst_q) ? st_turn_q - st_burst_q : '0;
			time_after <= clock_q;
			all_done   <= (fin_cnt_q >= proc_cnt_q);
			rejected   <= st_rejected_q;
		end
	end

endmodule

`default_nettype wire

[design/ppsu_ctrl.sv]
// Scheduler controller: sequences accept, decode, table scan, update and
// result output; owns the handshakes. Depends on ppsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppsu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ppsu_pkg::status_t status,
	output ppsu_pkg::cmd_t         cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd        = '0;
		cmd.accept = in_valid && (state_q == ST_IDLE);
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.load_write = 1'b1;
				if (status.req_tick && status.has_work) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_end) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[design/preemptive_priority_scheduler_unit.sv]
// Preemptive priority scheduler over a table of ppsu_pkg::MAX_PROCS processes.
// Each request word is a load (store arrival, burst, priority in the next free
// slot) or a tick (run the most urgent arrived, unfinished process for one time
// unit); every request gives exactly one result word. A load, a rejected load
// or a tick with nothing left to run passes from decode straight to the
// result stage; a tick with work first runs the winner search, which reads
// one table entry per cycle through the single read port of the table RAM,
// and then the update. The result sits in an output register, so the next
// request word is taken while it waits.
// Depends on ppsu_pkg, ppsu_req_if, ppsu_rsp_if, ppsu_ctrl, ppsu_dp.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	ppsu_req_if.sink  req,
	ppsu_rsp_if.source rsp
);

	ppsu_pkg::cmd_t    cmd;
	ppsu_pkg::status_t status;

	ppsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ppsu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.req_type      (req.req_type),
		.arrival_time  (req.arrival_time),
		.burst_length  (req.burst_length),
		.priority_level(req.priority_level),
		.run_valid     (rsp.run_valid),
		.run_slot      (rsp.run_slot),
		.switched      (rsp.switched),
		.finished      (rsp.finished),
		.turnaround    (rsp.turnaround),
		.waiting       (rsp.waiting),
		.time_after    (rsp.time_after),
		.all_done      (rsp.all_done),
		.rejected      (rsp.rejected)
	);

endmodule

`default_nettype wire

[design/ppsu_checker.sv]
// Port-level checks on the scheduler result channel, bound to the top level.
// Depends on ppsu_pkg and preemptive_priority_scheduler_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "preemptive_priority_scheduler_unit_macros.svh"

module ppsu_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            rsp_valid,
	input wire logic                            rsp_ready,
	input wire logic                            run_valid,
	input wire logic [ppsu_pkg::RUN_SLOT_W-1:0] run_slot,
	input wire logic                            switched,
	input wire logic                            finished,
	input wire logic [ppsu_pkg::TIME_W-1:0]     turnaround,
	input wire logic [ppsu_pkg::TIME_W-1:0]     waiting,
	input wire logic                            rejected
);

	// a rejected load never reports a run
	`PPSU_ASSERT_NOW(a_reject_no_run, clk, arst_n, rsp_valid && rejected,
		!run_valid && !finished && !switched, "rejected word reports a run")

	// completion only for a process that ran, and waiting never exceeds turnaround
	`PPSU_ASSERT_NOW(a_finish_ran, clk, arst_n, rsp_valid && finished,
		run_valid && (waiting <= turnaround), "finish without run or bad waiting")

	// no completion, no timing figures; no run, no slot
	`PPSU_ASSERT_NOW(a_idle_zero, clk, arst_n, rsp_valid && !finished && !run_valid,
		(turnaround == '0) && (waiting == '0) && (run_slot == '0) && !switched,
		"idle word carries figures")

	// a stalled word holds
	`PPSU_ASSERT_NEXT(a_stall_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(turnaround) && $stable(run_slot), "stalled word changed")

endmodule

bind preemptive_priority_scheduler_unit ppsu_checker u_ppsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.run_valid (rsp.run_valid),
	.run_slot  (rsp.run_slot),
	.switched  (rsp.switched),
	.finished  (rsp.finished),
	.turnaround(rsp.turnaround),
	.waiting   (rsp.waiting),
	.rejected  (rsp.rejected)
);

`default_nettype wire
